@@ hdl/lzh_pkg.sv @@
// shared constants and types for the lzh byte depacker
// used by the history ram, the output packer and the top level
package lzh_pkg;

  localparam int WindowDepth = 8192;
  localparam int HistAw      = $clog2(WindowDepth);
  localparam int MaxOutput   = 49152;
  // out count may pass the limit by one token and the final byte
  localparam int CountW      = $clog2(MaxOutput + 67);
  localparam int DistW       = 13;
  localparam int LenW        = 7;
  localparam int DistHiW     = 12;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatRange = 2'd1;
  localparam logic [1:0] StatTrunc = 2'd2;

  localparam logic CfgVersion = 1'b0;
  localparam logic CfgFinal   = 1'b1;

  // one decoded byte or a status-only event from the sequencer
  typedef struct packed {
    logic       valid;
    logic       has_byte;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
    logic       fin;
  } lzh_push_t;

endpackage

@@ hdl/lzh_byte_depacker_top.sv @@
// lzh byte depacker: token parser and byte-at-a-time expansion sequencer
// literal and run bytes are pushed from the fill state, a copy does a history
// read then write per byte, and the final byte has its own state; one decoded
// byte leaves the emit unit per cycle for runs while the output packer is ready
// input is not taken while an item is being expanded; no clearing pass, reset
// clears the parser, the counters, the configuration and the output item only
module lzh_byte_depacker_top import lzh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // packed_byte[7:0]
  input  logic [7:0]  s_axis_tdata,
  // end_of_data
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_first[7:0], byte_second[15:8], byte_count[17:16], status[19:18], zero pad
  output logic [23:0] m_axis_tdata,
  // final_res
  output logic        m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHK, ST_RD, ST_WR, ST_FILL, ST_FINAL, ST_STAT
  } state_e;

  typedef enum logic [1:0] {
    PH_TOKEN, PH_DIST, PH_RUN, PH_LIT
  } phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [7:0]         byte_q;
  logic               eod_q;
  logic [LenW-1:0]    pend_len_q, rep_q;
  logic [DistHiW-1:0] pend_hi_q;
  logic [DistW-1:0]   dist_q;
  logic [CountW-1:0]  out_cnt_q, cnt_inc;
  logic               finished_q, tok_end_q, trunc_q;
  logic [1:0]         stat_q;
  logic               version_q;
  logic [7:0]         final_q;

  lzh_push_t          push;
  logic               pk_ready, push_fire, in_fire, done_after, last_rep;
  logic [7:0]         rdata;
  logic [HistAw-1:0]  src_addr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cnt_inc       = out_cnt_q + CountW'(1);
  assign last_rep      = (rep_q == LenW'(1));
  // size limit is looked at only once a token is complete
  assign done_after    = tok_end_q && (eod_q || (cnt_inc >= CountW'(MaxOutput)));
  assign src_addr      = out_cnt_q[HistAw-1:0] - HistAw'(dist_q);

  always_comb begin
    push          = '0;
    push.status   = StatOk;
    case (state_q)
      ST_FILL, ST_WR: begin
        push.valid    = 1'b1;
        push.has_byte = 1'b1;
        push.data     = (state_q == ST_WR) ? rdata : byte_q;
        push.last     = last_rep && !done_after;
        push.status   = (last_rep && trunc_q) ? StatTrunc : StatOk;
        push.fin      = last_rep && trunc_q;
      end
      ST_FINAL: begin
        push.valid    = 1'b1;
        push.has_byte = 1'b1;
        push.data     = final_q;
        push.last     = 1'b1;
        push.fin      = 1'b1;
      end
      ST_STAT: begin
        push.valid    = 1'b1;
        push.last     = 1'b1;
        push.status   = stat_q;
        push.fin      = 1'b1;
      end
      default: ;
    endcase
  end

  assign push_fire = push.valid && pk_ready;

  lzh_hist_ram u_hist (
    .clk_i   (clk_i),
    .we_i    (push_fire && push.has_byte),
    .waddr_i (out_cnt_q[HistAw-1:0]),
    .wdata_i (push.data),
    .re_i    (state_q == ST_RD),
    .raddr_i (src_addr),
    .rdata_o (rdata)
  );

  lzh_out_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .ready_o       (pk_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_TOKEN;
      pend_len_q <= '0;
      pend_hi_q  <= '0;
      out_cnt_q  <= '0;
      finished_q <= 1'b0;
      version_q  <= 1'b0;
      final_q    <= 8'd0;
      rep_q      <= '0;
      tok_end_q  <= 1'b0;
      trunc_q    <= 1'b0;
      stat_q     <= StatOk;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgVersion: version_q <= cfg_wdata_i[0];
          CfgFinal:   final_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          // items after the end are taken and dropped
          if (in_fire && !finished_q) begin
            byte_q <= s_axis_tdata;
            eod_q  <= s_axis_tlast;
            case (phase_q)
              PH_TOKEN: begin
                if (s_axis_tdata == 8'd0) begin
                  state_q <= ST_FINAL;
                end else begin
                  if (s_axis_tdata[7]) begin
                    if (version_q) begin
                      pend_len_q <= LenW'(s_axis_tdata[7:4]) - LenW'(5);
                      pend_hi_q  <= {s_axis_tdata[3:0], 8'd0};
                    end else begin
                      pend_len_q <= LenW'(s_axis_tdata[3:0]) + LenW'(3);
                      pend_hi_q  <= {1'b0, s_axis_tdata[6:4], 8'd0};
                    end
                    phase_q <= PH_DIST;
                  end else if (s_axis_tdata[6]) begin
                    pend_len_q <= s_axis_tdata[6:0] - LenW'(61);
                    phase_q    <= PH_RUN;
                  end else begin
                    pend_len_q <= s_axis_tdata[6:0];
                    phase_q    <= PH_LIT;
                  end
                  if (s_axis_tlast) begin
                    stat_q  <= StatTrunc;
                    state_q <= ST_STAT;
                  end
                end
              end
              PH_DIST: begin
                dist_q  <= DistW'(pend_hi_q) + DistW'(s_axis_tdata) + DistW'(2);
                phase_q <= PH_TOKEN;
                state_q <= ST_CHK;
              end
              PH_RUN: begin
                rep_q      <= pend_len_q;
                pend_len_q <= '0;
                phase_q    <= PH_TOKEN;
                tok_end_q  <= 1'b1;
                trunc_q    <= 1'b0;
                state_q    <= ST_FILL;
              end
              default: begin
                rep_q <= LenW'(1);
                if (pend_len_q <= LenW'(1)) begin
                  pend_len_q <= '0;
                  phase_q    <= PH_TOKEN;
                  tok_end_q  <= 1'b1;
                  trunc_q    <= 1'b0;
                end else begin
                  pend_len_q <= pend_len_q - LenW'(1);
                  tok_end_q  <= 1'b0;
                  trunc_q    <= s_axis_tlast;
                end
                state_q <= ST_FILL;
              end
            endcase
          end
        end
        ST_CHK: begin
          pend_len_q <= '0;
          pend_hi_q  <= '0;
          if (CountW'(dist_q) > out_cnt_q) begin
            stat_q  <= StatRange;
            state_q <= ST_STAT;
          end else begin
            rep_q     <= pend_len_q;
            tok_end_q <= 1'b1;
            trunc_q   <= 1'b0;
            state_q   <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_WR;
        end
        ST_WR, ST_FILL: begin
          if (push_fire) begin
            out_cnt_q <= cnt_inc;
            rep_q     <= rep_q - LenW'(1);
            if (last_rep) begin
              if (done_after) begin
                state_q <= ST_FINAL;
              end else begin
                finished_q <= trunc_q;
                state_q    <= ST_IDLE;
              end
            end else if (state_q == ST_WR) begin
              state_q <= ST_RD;
            end
          end
        end
        ST_FINAL: begin
          if (push_fire) begin
            out_cnt_q  <= cnt_inc;
            finished_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        ST_STAT: begin
          if (push_fire) begin
            finished_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/lzh_hist_ram.sv @@
// history window of decoded bytes, one write and one registered read port
// depends on lzh_pkg for depth and address width
module lzh_hist_ram import lzh_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [HistAw-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [HistAw-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem [WindowDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lzh_out_pack.sv @@
// pairs decoded bytes into result items and holds one item for the output
// depends on lzh_pkg for the push struct
module lzh_out_pack import lzh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lzh_push_t  push_i,
  output logic       ready_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // byte_first[7:0], byte_second[15:8], byte_count[17:16], status[19:18], zero pad
  output logic [23:0] m_axis_tdata,
  // final_res
  output logic       m_axis_tlast
);

  logic       m_valid_q;
  logic       have_q;
  logic [7:0] held_q;
  logic [7:0] first_q, second_q;
  logic [1:0] count_q, status_q;
  logic       fin_q;
  logic       can_load, hold, fire;

  assign can_load = !m_valid_q || m_axis_tready;
  assign hold     = push_i.has_byte && !have_q && !push_i.last;
  assign ready_o  = hold || can_load;
  assign fire     = push_i.valid && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      have_q    <= 1'b0;
    end else begin
      if (fire && !hold) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (fire) begin
        if (hold) begin
          have_q <= 1'b1;
          held_q <= push_i.data;
        end else begin
          have_q    <= 1'b0;
          status_q  <= push_i.last ? push_i.status : StatOk;
          fin_q     <= push_i.last && push_i.fin;
          if (have_q) begin
            first_q  <= held_q;
            second_q <= push_i.has_byte ? push_i.data : 8'd0;
            count_q  <= push_i.has_byte ? 2'd2 : 2'd1;
          end else begin
            first_q  <= push_i.has_byte ? push_i.data : 8'd0;
            second_q <= 8'd0;
            count_q  <= push_i.has_byte ? 2'd1 : 2'd0;
          end
        end
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, status_q, count_q, second_q, first_q};
  assign m_axis_tlast  = fin_q;

endmodule

@@ dv/lzh_depack_checker.sv @@
// scoreboard for the lzh byte depacker: mirrors the token parser and the history
// window, predicts every decoded result item and compares it with the output port
// depends on lzh_pkg for the window size, the output limit, status codes and indexes
module lzh_depack_checker import lzh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic        out_last_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  typedef enum logic [1:0] {PhToken, PhDist, PhRun, PhLit} parse_phase_e;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] count;
    logic [1:0] status;
    logic       fin;
  } decoded_item_t;

  localparam logic [7:0]  EndToken = 8'h00;
  localparam int unsigned RunBias  = 61;

  logic [7:0]    window_mem [WindowDepth];
  int unsigned   produced;
  parse_phase_e  phase;
  int unsigned   pend_len;
  int unsigned   pend_dist_hi;
  logic          stream_done;
  logic          ver_mode;
  logic [7:0]    tail_byte;
  logic [7:0]    step_bytes [$];
  decoded_item_t decoded_q [$];
  int            mismatches;

  function automatic void put_byte(input logic [7:0] b);
    window_mem[produced % WindowDepth] = b;
    step_bytes.insert(step_bytes.size(), b);
    produced++;
  endfunction

  function automatic void depack_predict(input logic [7:0] b, input logic eod);
    logic [1:0]    stat;
    logic          ends;
    logic          tok_end;
    int unsigned   back_dist;
    int            nres;
    int            cnt;
    decoded_item_t r;
    if (stream_done) return;
    step_bytes.delete();
    stat    = StatOk;
    ends    = 1'b0;
    tok_end = 1'b0;
    case (phase)
      PhToken: begin
        if (b == EndToken) begin
          ends = 1'b1;
        end else begin
          if (b[7]) begin
            // copy token, field layout follows the format latched now
            if (ver_mode) begin
              pend_len     = int'(b[7:4]) - 5;
              pend_dist_hi = int'(b[3:0]) << 8;
            end else begin
              pend_len     = int'(b[3:0]) + 3;
              pend_dist_hi = int'(b[6:4]) << 8;
            end
            phase = PhDist;
          end else if (b[6]) begin
            pend_len = int'(b) - RunBias;
            phase    = PhRun;
          end else begin
            pend_len = int'(b);
            phase    = PhLit;
          end
          if (eod) stat = StatTrunc;
        end
      end
      PhDist: begin
        back_dist = pend_dist_hi + int'(b) + 2;
        if (back_dist > produced) begin
          stat = StatRange;
        end else begin
          // byte by byte so that an overlapping copy repeats itself
          repeat (pend_len) put_byte(window_mem[(produced - back_dist) % WindowDepth]);
          tok_end = 1'b1;
        end
        phase        = PhToken;
        pend_len     = 0;
        pend_dist_hi = 0;
      end
      PhRun: begin
        repeat (pend_len) put_byte(b);
        pend_len = 0;
        phase    = PhToken;
        tok_end  = 1'b1;
      end
      default: begin
        put_byte(b);
        if (pend_len > 0) pend_len--;
        if (pend_len == 0) begin
          phase   = PhToken;
          tok_end = 1'b1;
        end else if (eod) begin
          stat = StatTrunc;
        end
      end
    endcase

    // size limit is only looked at between tokens
    if (tok_end && (eod || produced >= MaxOutput)) ends = 1'b1;
    if (ends && stat == StatOk) put_byte(tail_byte);
    if (ends || stat != StatOk) stream_done = 1'b1;

    nres = (step_bytes.size() + 1) / 2;
    if (nres == 0 && stat != StatOk) nres = 1;
    for (int i = 0; i < nres; i++) begin
      cnt = step_bytes.size() - 2 * i;
      if (cnt > 2) cnt = 2;
      if (cnt < 0) cnt = 0;
      r.first  = (cnt >= 1) ? step_bytes[2 * i] : 8'h00;
      r.second = (cnt >= 2) ? step_bytes[2 * i + 1] : 8'h00;
      r.count  = cnt[1:0];
      r.status = (i == nres - 1) ? stat : StatOk;
      r.fin    = (i == nres - 1) && stream_done;
      decoded_q.insert(decoded_q.size(), r);
    end
  endfunction

  function automatic void check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_item_t e;
    if (!rst_ni) begin
      produced     = 0;
      phase        = PhToken;
      pend_len     = 0;
      pend_dist_hi = 0;
      stream_done  = 1'b0;
      ver_mode     = 1'b0;
      tail_byte    = 8'h00;
      mismatches   = 0;
      decoded_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgVersion: ver_mode = cfg_wdata_i[0];
          CfgFinal:   tail_byte = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) depack_predict(in_data_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("result item with nothing expected: tdata %h tlast %b", out_data_i, out_last_i);
          mismatches++;
        end else begin
          e = decoded_q.pop_front();
          check_field("byte_first", int'(e.first), int'(out_data_i[7:0]));
          check_field("byte_second", int'(e.second), int'(out_data_i[15:8]));
          check_field("byte_count", int'(e.count), int'(out_data_i[17:16]));
          check_field("status", int'(e.status), int'(out_data_i[19:18]));
          check_field("final_res", int'(e.fin), int'(out_last_i));
        end
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= decoded_q.size();
  end

endmodule

@@ dv/tb_lzh_byte_depacker_top.sv @@
// testbench top for the lzh byte depacker: drives one packed stream in phases
// under both token formats, with bursty input and a stalling output side
// depends on lzh_pkg, lzh_byte_depacker_top and lzh_depack_checker
module tb_lzh_byte_depacker_top;
  import lzh_pkg::*;

  localparam int          DrainCycles = 80;
  localparam int          StallLimit  = 2000;
  localparam logic [7:0]  EndToken    = 8'h00;
  localparam int unsigned RunBias     = 61;

  typedef enum int {
    EndZero, EndEodLit, EndEodRun, EndEodCopy, EndTruncToken, EndTruncLit, EndRange
  } stream_end_e;

  typedef enum int {RdyFull, RdyCoin, RdySparse, RdyBeat} ready_pattern_e;

  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           cfg_we_i      = 1'b0;
  logic           cfg_idx_i     = CfgVersion;
  logic [7:0]     cfg_wdata_i   = 8'h00;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [7:0]     s_axis_tdata  = 8'h00;
  logic           s_axis_tlast  = 1'b0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [23:0]    m_axis_tdata;
  logic           m_axis_tlast;
  int             mismatch_count;
  int             outstanding;
  int             idle_cycles   = 0;
  int             burst_left    = 0;
  int             sent_items    = 0;
  int unsigned    decoded_total = 0;
  logic           cur_ver       = 1'b0;
  ready_pattern_e ready_mode    = RdyFull;
  int             mode_left     = 0;

  always #1 clk_i = ~clk_i;

  lzh_byte_depacker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lzh_depack_checker depack_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_last_i        (s_axis_tlast),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // receiver switches between stall patterns picked at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_pattern_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        RdyFull:   m_axis_tready <= 1'b1;
        RdyCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
        RdySparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (mode_left % 4) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eod;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  task automatic cfg_write(input logic ver, input logic [7:0] tail);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgVersion;
    cfg_wdata_i <= {7'd0, ver};
    @(posedge clk_i);
    cfg_idx_i   <= CfgFinal;
    cfg_wdata_i <= tail;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_ver = ver;
  endtask

  // hold input until every predicted item is out, then let the expansion settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_literal(input int n, input logic eod);
    send_byte(8'(n), 1'b0);
    for (int i = 1; i <= n; i++) send_byte(8'($urandom), eod && (i == n));
    decoded_total += n;
  endtask

  task automatic send_run(input logic [7:0] tok, input logic eod);
    send_byte(tok, 1'b0);
    send_byte(8'($urandom), eod);
    decoded_total += int'(tok) - RunBias;
  endtask

  // copy whose distance stays inside what has been decoded so far
  task automatic send_copy(input logic eod);
    int unsigned reach;
    int unsigned top_hi;
    int unsigned hi;
    int unsigned room;
    logic [7:0]  tok;
    reach  = (decoded_total - 2) / 256;
    top_hi = cur_ver ? 15 : 7;
    if (reach < top_hi) top_hi = reach;
    hi = ($urandom_range(0, 3) == 0) ? top_hi : $urandom_range(0, top_hi);
    if (cur_ver)
      tok = {4'($urandom_range(8, 15)), 4'(hi)};
    else
      tok = {1'b1, 3'(hi), 4'($urandom_range(0, 15))};
    room = decoded_total - 2 - hi * 256;
    send_byte(tok, 1'b0);
    send_byte(8'((room > 255) ? $urandom_range(0, 255) : $urandom_range(0, room)), eod);
    decoded_total += cur_ver ? int'(tok[7:4]) - 5 : int'(tok[3:0]) + 3;
  endtask

  task automatic send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35 || decoded_total < 2)
      send_literal(($urandom_range(0, 7) == 0) ? $urandom_range(7, 63) : $urandom_range(1, 6),
                   1'b0);
    else if (pick < 65)
      send_run(8'($urandom_range(64, 127)), 1'b0);
    else
      send_copy(1'b0);
  endtask

  // copy reaching past the start of the output, else a cut token
  task automatic send_range_fault();
    int unsigned maxd;
    int unsigned far_dist;
    int unsigned hi;
    logic [7:0]  tok;
    maxd = cur_ver ? (15 << 8) + 257 : (7 << 8) + 257;
    if (decoded_total + 1 > maxd) begin
      send_byte(8'($urandom_range(1, 255)), 1'b1);
      return;
    end
    far_dist = $urandom_range(0, 1) ? decoded_total + 1
                                    : $urandom_range(decoded_total + 1, maxd);
    hi   = (far_dist - 2) >> 8;
    if (cur_ver)
      tok = {4'($urandom_range(8, 15)), 4'(hi)};
    else
      tok = {1'b1, 3'(hi), 4'($urandom_range(0, 15))};
    send_byte(tok, 1'b0);
    send_byte(8'(far_dist - 2), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    stream_end_e how;
    int          lit_len;
    int          cut;
    int          tail_pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // format 1, final byte low
    cfg_write(1'b0, 8'h00);
    send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h40, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h00, 1'b0);
    // shortest copy at the nearest distance overlaps its own output
    send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h8F, 1'b0); send_byte(8'h45, 1'b0);
    send_byte(8'h55, 1'b0); send_byte(8'hAA, 1'b0);
    decoded_total = 117;
    drain();

    // format 2, final byte high
    cfg_write(1'b1, 8'hFF);
    send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h05, 1'b0);
    decoded_total += 13;
    send_literal(63, 1'b0);
    while (sent_items < 100) send_random_token();
    drain();

    cfg_write(1'b0, 8'($urandom_range(1, 254)));
    while (sent_items < 135) send_random_token();
    drain();

    tail_pick = $urandom_range(0, 2);
    cfg_write(1'($urandom_range(0, 1)),
              (tail_pick == 0) ? 8'h00 : (tail_pick == 1) ? 8'hFF : 8'($urandom));
    while (sent_items < 160) send_random_token();

    how = stream_end_e'($urandom_range(0, 6));
    case (how)
      EndZero:       send_byte(EndToken, 1'($urandom_range(0, 1)));
      EndEodLit:     send_literal($urandom_range(1, 63), 1'b1);
      EndEodRun:     send_run(8'($urandom_range(64, 127)), 1'b1);
      EndEodCopy:    send_copy(1'b1);
      EndTruncToken: send_byte(8'($urandom_range(1, 255)), 1'b1);
      EndTruncLit: begin
        lit_len = $urandom_range(2, 63);
        cut     = $urandom_range(1, lit_len - 1);
        send_byte(8'(lit_len), 1'b0);
        for (int i = 1; i <= cut; i++) send_byte(8'($urandom), i == cut);
      end
      default:       send_range_fault();
    endcase

    // stream is over, these items must be dropped
    repeat (3) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    drain();

    if (mismatch_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lzh_pkg.sv
hdl/lzh_hist_ram.sv
hdl/lzh_out_pack.sv
hdl/lzh_byte_depacker_top.sv
dv/lzh_depack_checker.sv
dv/tb_lzh_byte_depacker_top.sv
